/* hdl/i2csrm_pkg.sv */
package i2csrm_pkg;

    localparam int MAP_DEPTH = 256;
    localparam int MAP_AW    = $clog2(MAP_DEPTH);

    localparam logic [7:0] OFF_BLOCK_START  = 8'h20;
    localparam logic [7:0] OFF_BLOCK_STATUS = 8'h32;

    // 0x30 on the wire is 7-bit address 0x18
    localparam logic [6:0] OWN_ADDR_RST    = 7'h18;
    localparam logic [7:0] WRITE_LIMIT_RST = 8'hC8;
    localparam logic [7:0] MARKER_RST      = 8'd250;

    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 24;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    typedef enum logic [2:0] {
        OP_ADDR   = 3'd0,
        OP_TX     = 3'd1,
        OP_RX     = 3'd2,
        OP_STOP   = 3'd3,
        OP_LWRITE = 3'd4,
        OP_LREAD  = 3'd5
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OWN_ADDR    = 2'd0,
        CFG_WRITE_LIMIT = 2'd1,
        CFG_MARKER      = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic latch;    // take the input beat, issue map read
        logic exec;     // evaluate, update map/pointer, load result
        logic mark_wr;  // write marker into status byte
    } cmd_t;

    typedef struct packed {
        logic out_free;
        logic mark_hit;
    } stat_t;

endpackage

/* hdl/i2csrm_ram.sv */
module i2csrm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* hdl/i2csrm_ctrl.sv */
module i2csrm_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  i2csrm_pkg::stat_t    stat,
    output i2csrm_pkg::cmd_t     cmd
);
    import i2csrm_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_MARK = 3'b100
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next  = state_reg;
        in_ready    = 1'b0;
        cmd         = '0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (stat.out_free)
                begin
                    cmd.exec   = 1'b1;
                    state_next = stat.mark_hit ? S_MARK : S_IDLE;
                end
            end
            S_MARK:
            begin
                cmd.mark_wr = 1'b1;
                state_next  = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* hdl/i2csrm_dp.sv */
module i2csrm_dp (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [i2csrm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [i2csrm_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  logic [2:0]                           in_op,
    input  logic [i2csrm_pkg::IN_DATA_W-1:0]     in_data,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [i2csrm_pkg::OUT_DATA_W-1:0]    out_data,
    input  i2csrm_pkg::cmd_t                     cmd,
    output i2csrm_pkg::stat_t                    stat
);
    import i2csrm_pkg::*;

    // configuration
    logic [6:0] own_addr_reg;
    logic [7:0] limit_reg;
    logic [7:0] marker_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_addr_reg <= OWN_ADDR_RST;
            limit_reg    <= WRITE_LIMIT_RST;
            marker_reg   <= MARKER_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_OWN_ADDR:    own_addr_reg <= cfg_wdata[6:0];
                CFG_WRITE_LIMIT: limit_reg    <= cfg_wdata;
                CFG_MARKER:      marker_reg   <= cfg_wdata;
                default:         ;
            endcase
        end
    end

    // latched item
    op_t        op_reg;
    logic [6:0] addr_reg;
    logic       rd_reg;
    logic [7:0] data_reg;
    logic [7:0] loff_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            op_reg   <= op_t'(in_op);
            addr_reg <= in_data[6:0];
            rd_reg   <= in_data[7];
            data_reg <= in_data[15:8];
            loff_reg <= in_data[23:16];
        end
    end

    // map: RAM plus per-entry written bits, unwritten entries read zero
    logic [MAP_DEPTH-1:0] vld_reg;
    logic                 vld_q_reg;
    logic [7:0]           ptr_reg, ptr_next;
    logic [MAP_AW-1:0]    raddr;
    logic [7:0]           ram_q;
    logic [7:0]           mem_byte;
    logic                 map_we;
    logic [MAP_AW-1:0]    map_waddr;
    logic [7:0]           map_wdata;

    assign raddr = (op_t'(in_op) == OP_LWRITE || op_t'(in_op) == OP_LREAD) ?
                   in_data[23:16] : ptr_reg;

    i2csrm_ram #(
        .WIDTH (8),
        .DEPTH (MAP_DEPTH)
    ) u_map (
        .clk   (clk),
        .we    (map_we),
        .waddr (map_waddr),
        .wdata (map_wdata),
        .re    (cmd.latch),
        .raddr (raddr),
        .rdata (ram_q)
    );

    assign mem_byte = vld_q_reg ? ram_q : 8'd0;

    // evaluation
    logic       ack, txv, mark, store;
    logic [7:0] txb, rdat;

    always_comb
    begin
        ack       = 1'b0;
        txv       = 1'b0;
        txb       = 8'd0;
        rdat      = 8'd0;
        mark      = 1'b0;
        store     = 1'b0;
        ptr_next  = ptr_reg;
        map_waddr = ptr_reg;
        map_wdata = data_reg;
        case (op_reg)
            OP_ADDR:
            begin
                if (addr_reg == own_addr_reg)
                begin
                    ack = 1'b1;
                    if (rd_reg)
                    begin
                        txv = 1'b1;
                        txb = mem_byte;
                    end
                    else
                    begin
                        ptr_next = 8'd0;
                    end
                end
            end
            OP_TX:
            begin
                txv      = 1'b1;
                txb      = mem_byte;
                ptr_next = ptr_reg + 8'd1;
            end
            OP_RX:
            begin
                if (ptr_reg == 8'd0)
                begin
                    ptr_next = data_reg;
                end
                else if (ptr_reg <= limit_reg)
                begin
                    store    = 1'b1;
                    ptr_next = ptr_reg + 8'd1;
                    mark     = (data_reg == marker_reg) && (ptr_reg == OFF_BLOCK_START);
                end
            end
            OP_LWRITE:
            begin
                store     = 1'b1;
                map_waddr = loff_reg;
            end
            OP_LREAD:
            begin
                rdat = mem_byte;
            end
            default: ;
        endcase
        if (cmd.mark_wr)
        begin
            map_waddr = OFF_BLOCK_STATUS;
            map_wdata = marker_reg;
        end
    end

    assign map_we = (cmd.exec && store) || cmd.mark_wr;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg   <= '0;
            vld_q_reg <= 1'b0;
            ptr_reg   <= 8'd0;
        end
        else
        begin
            if (cmd.latch)
            begin
                vld_q_reg <= vld_reg[raddr];
            end
            if (map_we)
            begin
                vld_reg[map_waddr] <= 1'b1;
            end
            if (cmd.exec)
            begin
                ptr_reg <= ptr_next;
            end
        end
    end

    // result register
    logic                  out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.exec)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            out_data_reg <= {5'd0, mark, rdat, txb, txv, ack};
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_data      = out_data_reg;
    assign stat.out_free = !out_valid_reg || out_ready;
    assign stat.mark_hit = mark;

endmodule

/* hdl/i2c_slave_register_map_unit.sv */
// I2C target register map: 256-byte map with an 8-bit bus pointer, cleared at
// reset. Each input beat is one bus or local event (opcode on s_axis_tuser),
// and each produces exactly one result beat. The map RAM is read at the
// pointer or local offset when the beat is taken; once the result register
// is free the event is evaluated, written back and loaded into it. A marker
// byte stored at offset 0x20 adds a status write step, since the status byte
// 0x32 is written through the same single RAM write port. The next event is
// accepted while the previous result still waits on m_axis. Configuration
// writes are taken any time the block is idle.
module i2c_slave_register_map_unit (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [i2csrm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [i2csrm_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // [6:0] bus_address, [7] read_transfer, [15:8] data_byte, [23:16] local_offset
    input  logic [i2csrm_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // [2:0] opcode
    input  logic [2:0]                           s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // [0] addr_ack, [1] tx_valid, [9:2] tx_byte, [17:10] read_data,
    // [18] marker_seen, [23:19] zero
    output logic [i2csrm_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);
    import i2csrm_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    i2csrm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    i2csrm_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_op     (s_axis_tuser),
        .in_data   (s_axis_tdata),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata),
        .cmd       (cmd),
        .stat      (stat)
    );

    a_exec_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec |-> stat.out_free)
        else $error("result loaded while output register still full");

    a_exec_gives_beat: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec |=> m_axis_tvalid)
        else $error("evaluated event produced no result beat");

    a_mark_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mark_wr |-> $past(cmd.exec) && $past(stat.mark_hit))
        else $error("status write without a marker hit");

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.exec || cmd.mark_wr) |-> !s_axis_tready)
        else $error("input accepted while an event is in flight");

endmodule

/* bench/tb_i2c_slave_register_map_unit.sv */
`timescale 1ns / 1ps

module tb_i2c_slave_register_map_unit;
    import i2csrm_pkg::*;

    localparam int         CYCLE_LIMIT = 400000;
    localparam int         MAX_PRINTS  = 40;
    localparam int         RAND_PHASES = 6;
    localparam int         PHASE_BEATS = 86;
    localparam logic [2:0] OP_SPARE6   = 3'd6;
    localparam logic [2:0] OP_SPARE7   = 3'd7;

    typedef struct packed {
        logic [2:0] op;
        logic [6:0] bus_address;
        logic       read_transfer;
        logic [7:0] data_byte;
        logic [7:0] local_offset;
    } bus_evt_t;

    typedef struct packed {
        logic       addr_ack;
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic [7:0] read_data;
        logic       marker_seen;
    } evt_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic [2:0]            s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    // shadow of the block state and configuration
    logic [7:0] map_img [0:MAP_DEPTH-1];
    logic [7:0] ptr_img;
    logic [6:0] own_addr_cfg;
    logic [7:0] wr_limit_cfg;
    logic [7:0] marker_cfg;

    bus_evt_t    pending_evts [$];
    evt_result_t expected_results [$];
    bus_evt_t    cur_evt;

    int  err_count = 0;
    int  evts_queued = 0;
    int  beats_sent = 0;
    int  results_checked = 0;
    int  acks_seen = 0;
    int  markers_seen = 0;
    int  settings_run = 0;
    int  cycle_count = 0;
    int  gap_left = 0;
    int  stall_left = 0;
    bit  quiet_phase = 1'b0;

    i2c_slave_register_map_unit i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 clk = ~clk;

    function automatic evt_result_t map_event_outcome(bus_evt_t ev);
        evt_result_t r;
        logic [7:0]  p;
        r = '0;
        p = ptr_img;
        case (ev.op)
            OP_ADDR:
            begin
                if (ev.bus_address == own_addr_cfg)
                begin
                    r.addr_ack = 1'b1;
                    if (ev.read_transfer)
                    begin
                        r.tx_valid = 1'b1;
                        r.tx_byte  = map_img[p];
                    end
                    else
                    begin
                        ptr_img = 8'd0;
                    end
                end
            end
            OP_TX:
            begin
                r.tx_valid = 1'b1;
                r.tx_byte  = map_img[p];
                ptr_img    = p + 8'd1;
            end
            OP_RX:
            begin
                if (p == 8'd0)
                begin
                    ptr_img = ev.data_byte;
                end
                else if (p <= wr_limit_cfg)
                begin
                    map_img[p] = ev.data_byte;
                    ptr_img    = p + 8'd1;
                    if (ev.data_byte == marker_cfg && p == OFF_BLOCK_START)
                    begin
                        map_img[OFF_BLOCK_STATUS] = marker_cfg;
                        r.marker_seen = 1'b1;
                    end
                end
            end
            OP_LWRITE: map_img[ev.local_offset] = ev.data_byte;
            OP_LREAD:  r.read_data = map_img[ev.local_offset];
            default: ;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] rnd8();
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet_phase)
            return 0;
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(4, 25);
    endfunction

    function automatic logic [7:0] bus_target();
        if ($urandom_range(0, 9) != 0)
            return {1'b0, own_addr_cfg};
        return rnd8();
    endfunction

    function automatic logic [7:0] pick_pointer();
        case ($urandom_range(0, 9))
            0, 1, 2: return OFF_BLOCK_START;
            3:       return wr_limit_cfg;
            4:       return wr_limit_cfg - 8'd1;
            5:       return 8'hFE;
            6:       return OFF_BLOCK_STATUS;
            default: return rnd8();
        endcase
    endfunction

    function automatic logic [7:0] pick_data();
        if ($urandom_range(0, 99) < 35)
            return marker_cfg;
        return rnd8();
    endfunction

    function automatic logic [7:0] pick_offset();
        case ($urandom_range(0, 4))
            0:       return OFF_BLOCK_START;
            1:       return OFF_BLOCK_STATUS;
            default: return rnd8();
        endcase
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        err_count++;
        if (err_count <= MAX_PRINTS)
            $display("[%0t] mismatch %s: got 0x%0h exp 0x%0h (result %0d)",
                     $realtime, what, got, want, results_checked);
    endtask

    // fields that the opcode does not use get random values
    task automatic push_evt(input logic [2:0] op, input logic [7:0] addr,
                            input logic [7:0] rd, input logic [7:0] data,
                            input logic [7:0] off);
        bus_evt_t ev;
        ev.op            = op;
        ev.bus_address   = addr[6:0];
        ev.read_transfer = rd[0];
        ev.data_byte     = data;
        ev.local_offset  = off;
        pending_evts.push_back(ev);
        evts_queued++;
    endtask

    task automatic write_cfg(input cfg_idx_t idx, input logic [7:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        case (idx)
            CFG_OWN_ADDR:    own_addr_cfg = value[6:0];
            CFG_WRITE_LIMIT: wr_limit_cfg = value;
            default:         marker_cfg   = value;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_evts.size() != 0 || s_axis_tvalid || expected_results.size() != 0);
        repeat (5) @(posedge clk);
    endtask

    task automatic gen_random_traffic(input int n_beats);
        int stop_at;
        int kind;
        stop_at = evts_queued + n_beats;
        while (evts_queued < stop_at)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 40)
            begin
                push_evt(OP_ADDR, bus_target(), 8'd0, rnd8(), rnd8());
                push_evt(OP_RX, rnd8(), rnd8(), pick_pointer(), rnd8());
                repeat ($urandom_range(1, 6))
                    push_evt(OP_RX, rnd8(), rnd8(), pick_data(), rnd8());
                if ($urandom_range(0, 3) != 0)
                    push_evt(OP_STOP, rnd8(), rnd8(), rnd8(), rnd8());
            end
            else if (kind < 70)
            begin
                if ($urandom_range(0, 1) != 0)
                begin
                    push_evt(OP_ADDR, bus_target(), 8'd0, rnd8(), rnd8());
                    push_evt(OP_RX, rnd8(), rnd8(), pick_pointer(), rnd8());
                end
                push_evt(OP_ADDR, bus_target(), 8'd1, rnd8(), rnd8());
                repeat ($urandom_range(1, 5))
                    push_evt(OP_TX, rnd8(), rnd8(), rnd8(), rnd8());
                push_evt(OP_STOP, rnd8(), rnd8(), rnd8(), rnd8());
            end
            else if (kind < 85)
            begin
                if ($urandom_range(0, 1) != 0)
                    push_evt(OP_LWRITE, rnd8(), rnd8(), pick_data(), pick_offset());
                else
                    push_evt(OP_LREAD, rnd8(), rnd8(), rnd8(), pick_offset());
            end
            else
            begin
                push_evt(3'($urandom_range(0, 7)), rnd8(), rnd8(), rnd8(), rnd8());
            end
        end
    endtask

    task automatic gen_directed();
        logic [7:0] own;
        own = {1'b0, OWN_ADDR_RST};
        // marker at the block start offset
        push_evt(OP_ADDR, own, 8'd0, rnd8(), rnd8());
        push_evt(OP_RX, rnd8(), rnd8(), OFF_BLOCK_START, rnd8());
        push_evt(OP_RX, rnd8(), rnd8(), MARKER_RST, rnd8());
        push_evt(OP_RX, rnd8(), rnd8(), 8'hFF, rnd8());
        // address mismatch at both ends
        push_evt(OP_ADDR, 8'h7F, 8'd1, rnd8(), rnd8());
        push_evt(OP_ADDR, 8'h00, 8'd0, rnd8(), rnd8());
        // read offers the byte without advancing
        push_evt(OP_ADDR, own, 8'd1, rnd8(), rnd8());
        push_evt(OP_TX, rnd8(), rnd8(), rnd8(), rnd8());
        // marker away from the block start
        push_evt(OP_ADDR, own, 8'd0, rnd8(), rnd8());
        push_evt(OP_RX, rnd8(), rnd8(), OFF_BLOCK_START - 8'd1, rnd8());
        push_evt(OP_RX, rnd8(), rnd8(), MARKER_RST, rnd8());
        push_evt(OP_RX, rnd8(), rnd8(), 8'h00, rnd8());
        // store at the limit, drop above it
        push_evt(OP_ADDR, own, 8'd0, rnd8(), rnd8());
        push_evt(OP_RX, rnd8(), rnd8(), WRITE_LIMIT_RST, rnd8());
        push_evt(OP_RX, rnd8(), rnd8(), 8'h77, rnd8());
        push_evt(OP_RX, rnd8(), rnd8(), 8'h66, rnd8());
        // pointer wrap on transmit
        push_evt(OP_ADDR, own, 8'd0, rnd8(), rnd8());
        push_evt(OP_RX, rnd8(), rnd8(), 8'hFE, rnd8());
        push_evt(OP_ADDR, own, 8'd1, rnd8(), rnd8());
        repeat (3)
            push_evt(OP_TX, rnd8(), rnd8(), rnd8(), rnd8());
        push_evt(OP_STOP, rnd8(), rnd8(), rnd8(), rnd8());
        push_evt(OP_SPARE6, rnd8(), rnd8(), rnd8(), rnd8());
        push_evt(OP_SPARE7, rnd8(), rnd8(), rnd8(), rnd8());
        // local access never flags the marker
        push_evt(OP_LWRITE, rnd8(), rnd8(), MARKER_RST, OFF_BLOCK_START);
        push_evt(OP_LWRITE, rnd8(), rnd8(), 8'hA5, 8'hFF);
        push_evt(OP_LREAD, rnd8(), rnd8(), rnd8(), 8'h00);
        push_evt(OP_LREAD, rnd8(), rnd8(), rnd8(), 8'hFF);
        push_evt(OP_LREAD, rnd8(), rnd8(), rnd8(), OFF_BLOCK_STATUS);
    endtask

    task automatic check_result(input logic [OUT_DATA_W-1:0] d);
        evt_result_t e;
        if (expected_results.size() == 0)
        begin
            report_mismatch("beat with nothing expected", int'(d), 0);
            return;
        end
        e = expected_results.pop_front();
        results_checked++;
        if (e.addr_ack)
            acks_seen++;
        if (e.marker_seen)
            markers_seen++;
        if (d[0] !== e.addr_ack)
            report_mismatch("addr_ack", int'(d[0]), int'(e.addr_ack));
        if (d[1] !== e.tx_valid)
            report_mismatch("tx_valid", int'(d[1]), int'(e.tx_valid));
        if (d[9:2] !== e.tx_byte)
            report_mismatch("tx_byte", int'(d[9:2]), int'(e.tx_byte));
        if (d[17:10] !== e.read_data)
            report_mismatch("read_data", int'(d[17:10]), int'(e.read_data));
        if (d[18] !== e.marker_seen)
            report_mismatch("marker_seen", int'(d[18]), int'(e.marker_seen));
    endtask

    // input driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= '0;
            gap_left = 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                expected_results.push_back(map_event_outcome(cur_evt));
                beats_sent++;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    s_axis_tvalid <= 1'b0;
                end
                else if (pending_evts.size() != 0)
                begin
                    cur_evt = pending_evts.pop_front();
                    s_axis_tdata  <= {cur_evt.local_offset, cur_evt.data_byte,
                                      cur_evt.read_transfer, cur_evt.bus_address};
                    s_axis_tuser  <= cur_evt.op;
                    s_axis_tvalid <= 1'b1;
                    gap_left = idle_gap();
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
                check_result(m_axis_tdata);
            if (stall_left > 0)
            begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                if ($urandom_range(0, 4) == 0)
                    stall_left = idle_gap();
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("** i2c_slave_register_map_unit: FAILED **");
            $finish;
        end
    end

    initial
    begin
        for (int i = 0; i < MAP_DEPTH; i++)
            map_img[i] = 8'd0;
        ptr_img      = 8'd0;
        own_addr_cfg = OWN_ADDR_RST;
        wr_limit_cfg = WRITE_LIMIT_RST;
        marker_cfg   = MARKER_RST;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        settings_run = 1;
        gen_directed();
        wait_drained();

        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            quiet_phase = (ph == 2 || ph == 4);
            case (ph)
                0:
                begin
                    write_cfg(CFG_OWN_ADDR, {1'b1, OWN_ADDR_RST});
                    write_cfg(CFG_WRITE_LIMIT, WRITE_LIMIT_RST);
                    write_cfg(CFG_MARKER, MARKER_RST);
                end
                1:
                begin
                    write_cfg(CFG_OWN_ADDR, 8'h00);
                    write_cfg(CFG_WRITE_LIMIT, 8'h00);
                    write_cfg(CFG_MARKER, 8'h00);
                end
                2:
                begin
                    write_cfg(CFG_OWN_ADDR, 8'h7F);
                    write_cfg(CFG_WRITE_LIMIT, 8'hFF);
                    write_cfg(CFG_MARKER, 8'hFF);
                end
                default:
                begin
                    write_cfg(CFG_OWN_ADDR, rnd8());
                    write_cfg(CFG_WRITE_LIMIT, rnd8());
                    write_cfg(CFG_MARKER, rnd8());
                end
            endcase
            settings_run++;
            gen_random_traffic(PHASE_BEATS);
            wait_drained();
        end

        repeat (10) @(posedge clk);
        if (expected_results.size() != 0)
            report_mismatch("results never seen", expected_results.size(), 0);

        $display("covered %0d events over %0d register settings", beats_sent, settings_run);
        $display("%0d results checked, %0d address acks, %0d marker flags, %0d errors",
                 results_checked, acks_seen, markers_seen, err_count);
        if (err_count == 0)
            $display("** i2c_slave_register_map_unit: PASSED **");
        else
            $display("** i2c_slave_register_map_unit: FAILED **");
        $finish;
    end

endmodule

/* i2c_slave_register_map_unit.f */
hdl/i2csrm_pkg.sv
hdl/i2csrm_ram.sv
hdl/i2csrm_ctrl.sv
hdl/i2csrm_dp.sv
hdl/i2c_slave_register_map_unit.sv
bench/tb_i2c_slave_register_map_unit.sv
